FILE: hdl/gtp_pkg.sv
// ============================================================================
// gtp_pkg
// Shared constants, register indexes and types for the go-to-point law.
// ============================================================================
package gtp_pkg;

    localparam int CMD_MAX      = 16383;
    localparam int CMD_MIN      = -16384;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 15;
    localparam int CORDIC_STEPS = 16;

    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [18:0] CORDIC_K    = 19'sd39797;

    typedef enum logic [2:0] {
        REG_TARGET_X       = 3'd0,
        REG_TARGET_Y       = 3'd1,
        REG_ARRIVAL_RADIUS = 3'd2,
        REG_LINEAR_GAIN    = 3'd3,
        REG_ANGULAR_GAIN   = 3'd4
    } reg_idx_t;

    // operands for the unit-vector unit
    typedef struct packed {
        logic [33:0] dist_sq;
        logic [16:0] mag_x;
        logic [16:0] mag_y;
        logic        neg_x;
        logic        neg_y;
    } uv_in_t;

    function automatic logic signed [20:0] atan_q16(input int unsigned idx);
        logic signed [20:0] a;
        case (idx)
            0:       a = 21'sd51472;
            1:       a = 21'sd30386;
            2:       a = 21'sd16055;
            3:       a = 21'sd8150;
            4:       a = 21'sd4091;
            5:       a = 21'sd2047;
            6:       a = 21'sd1024;
            7:       a = 21'sd512;
            8:       a = 21'sd256;
            9:       a = 21'sd128;
            10:      a = 21'sd64;
            11:      a = 21'sd32;
            12:      a = 21'sd16;
            13:      a = 21'sd8;
            14:      a = 21'sd4;
            15:      a = 21'sd2;
            default: a = 21'sd0;
        endcase
        return a;
    endfunction

endpackage

FILE: hdl/gtp_cordic.sv
// ============================================================================
// gtp_cordic
// Pipelined rotation-mode CORDIC: sine and cosine of a Q3.13 heading in Q16.
// ============================================================================
module gtp_cordic
    import gtp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] heading,
    output logic signed [18:0] sin_q,
    output logic signed [18:0] cos_q
);

    logic signed [18:0] x_reg    [CORDIC_STEPS];
    logic signed [18:0] y_reg    [CORDIC_STEPS];
    logic signed [20:0] z_reg    [CORDIC_STEPS];
    logic               flip_reg [CORDIC_STEPS];

    logic signed [20:0] z_raw;
    logic signed [20:0] z_fold;
    logic               flip_fold;

    // reduce by pi into [-pi/2, pi/2]
    always_comb
    begin
        z_raw     = 21'(heading) <<< 3;
        z_fold    = z_raw;
        flip_fold = 1'b0;
        if (z_raw > HALF_PI_Q16)
        begin
            z_fold    = z_raw - PI_Q16;
            flip_fold = 1'b1;
        end
        else if (z_raw < -HALF_PI_Q16)
        begin
            z_fold    = z_raw + PI_Q16;
            flip_fold = 1'b1;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [18:0] x_src;
        logic signed [18:0] y_src;
        logic signed [20:0] z_src;
        logic               f_src;
        logic signed [18:0] x_next;
        logic signed [18:0] y_next;
        logic signed [20:0] z_next;

        if (i == 0)
        begin : g_first
            assign x_src = CORDIC_K;
            assign y_src = 19'sd0;
            assign z_src = z_fold;
            assign f_src = flip_fold;
        end
        else
        begin : g_rest
            assign x_src = x_reg[i-1];
            assign y_src = y_reg[i-1];
            assign z_src = z_reg[i-1];
            assign f_src = flip_reg[i-1];
        end

        always_comb
        begin
            if (z_src >= 0)
            begin
                x_next = x_src - (y_src >>> i);
                y_next = y_src + (x_src >>> i);
                z_next = z_src - atan_q16(i);
            end
            else
            begin
                x_next = x_src + (y_src >>> i);
                y_next = y_src - (x_src >>> i);
                z_next = z_src + atan_q16(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                flip_reg[i] <= f_src;
            end
        end
    end

    assign cos_q = flip_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
    assign sin_q = flip_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];

endmodule

FILE: hdl/gtp_unit_vec.sv
// ============================================================================
// gtp_unit_vec
// Pipelined unit vector toward the target: one root bit per stage, then one
// quotient bit per stage for each axis. Result is Q1.14, rounded toward zero.
// ============================================================================
module gtp_unit_vec
    import gtp_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  uv_in_t             op,
    output logic signed [15:0] ux,
    output logic signed [15:0] uy
);

    logic [63:0] sq_v_reg  [SQRT_STEPS];
    logic [63:0] sq_r_reg  [SQRT_STEPS];
    logic [16:0] sq_mx_reg [SQRT_STEPS];
    logic [16:0] sq_my_reg [SQRT_STEPS];
    logic        sq_nx_reg [SQRT_STEPS];
    logic        sq_ny_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
        logic [63:0] v_src;
        logic [63:0] r_src;
        logic [16:0] mx_src;
        logic [16:0] my_src;
        logic        nx_src;
        logic        ny_src;
        logic [63:0] trial;

        if (k == 0)
        begin : g_first
            assign v_src  = {op.dist_sq, 30'd0};
            assign r_src  = 64'd0;
            assign mx_src = op.mag_x;
            assign my_src = op.mag_y;
            assign nx_src = op.neg_x;
            assign ny_src = op.neg_y;
        end
        else
        begin : g_rest
            assign v_src  = sq_v_reg[k-1];
            assign r_src  = sq_r_reg[k-1];
            assign mx_src = sq_mx_reg[k-1];
            assign my_src = sq_my_reg[k-1];
            assign nx_src = sq_nx_reg[k-1];
            assign ny_src = sq_ny_reg[k-1];
        end

        assign trial = r_src + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_src >= trial)
                begin
                    sq_v_reg[k] <= v_src - trial;
                    sq_r_reg[k] <= (r_src >> 1) + BIT;
                end
                else
                begin
                    sq_v_reg[k] <= v_src;
                    sq_r_reg[k] <= r_src >> 1;
                end
                sq_mx_reg[k] <= mx_src;
                sq_my_reg[k] <= my_src;
                sq_nx_reg[k] <= nx_src;
                sq_ny_reg[k] <= ny_src;
            end
        end
    end

    logic [46:0] dv_rx_reg [DIV_STEPS];
    logic [46:0] dv_ry_reg [DIV_STEPS];
    logic [14:0] dv_qx_reg [DIV_STEPS];
    logic [14:0] dv_qy_reg [DIV_STEPS];
    logic [31:0] dv_s_reg  [DIV_STEPS];
    logic        dv_nx_reg [DIV_STEPS];
    logic        dv_ny_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;
        logic [46:0] rx_src;
        logic [46:0] ry_src;
        logic [14:0] qx_src;
        logic [14:0] qy_src;
        logic [31:0] s_src;
        logic        nx_src;
        logic        ny_src;
        logic [46:0] dvs;

        if (j == 0)
        begin : g_first
            assign rx_src = {1'b0, sq_mx_reg[SQRT_STEPS-1], 29'd0};
            assign ry_src = {1'b0, sq_my_reg[SQRT_STEPS-1], 29'd0};
            assign qx_src = 15'd0;
            assign qy_src = 15'd0;
            assign s_src  = sq_r_reg[SQRT_STEPS-1][31:0];
            assign nx_src = sq_nx_reg[SQRT_STEPS-1];
            assign ny_src = sq_ny_reg[SQRT_STEPS-1];
        end
        else
        begin : g_rest
            assign rx_src = dv_rx_reg[j-1];
            assign ry_src = dv_ry_reg[j-1];
            assign qx_src = dv_qx_reg[j-1];
            assign qy_src = dv_qy_reg[j-1];
            assign s_src  = dv_s_reg[j-1];
            assign nx_src = dv_nx_reg[j-1];
            assign ny_src = dv_ny_reg[j-1];
        end

        assign dvs = 47'(s_src) << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rx_src >= dvs)
                begin
                    dv_rx_reg[j] <= rx_src - dvs;
                    dv_qx_reg[j] <= qx_src | (15'd1 << SH);
                end
                else
                begin
                    dv_rx_reg[j] <= rx_src;
                    dv_qx_reg[j] <= qx_src;
                end
                if (ry_src >= dvs)
                begin
                    dv_ry_reg[j] <= ry_src - dvs;
                    dv_qy_reg[j] <= qy_src | (15'd1 << SH);
                end
                else
                begin
                    dv_ry_reg[j] <= ry_src;
                    dv_qy_reg[j] <= qy_src;
                end
                dv_s_reg[j]  <= s_src;
                dv_nx_reg[j] <= nx_src;
                dv_ny_reg[j] <= ny_src;
            end
        end
    end

    logic signed [15:0] qx_s;
    logic signed [15:0] qy_s;

    assign qx_s = $signed({1'b0, dv_qx_reg[DIV_STEPS-1]});
    assign qy_s = $signed({1'b0, dv_qy_reg[DIV_STEPS-1]});
    assign ux   = dv_nx_reg[DIV_STEPS-1] ? -qx_s : qx_s;
    assign uy   = dv_ny_reg[DIV_STEPS-1] ? -qy_s : qy_s;

endmodule

FILE: hdl/go_to_point_velocity_law.sv
// ============================================================================
// go_to_point_velocity_law
// Proportional go-to-goal law: pose in, linear and turn commands out.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  pose     | in_valid, in_stall, pose_x/y, heading    | in
//  command  | out_valid, out_stall, *_cmd, arrived     | out
//  config   | wr_en, wr_index, wr_data                 | in
//
// One request enters per cycle while in_stall is low; a result passes through
// the 32-stage root and the 15-stage divider in series.
// Reset clears the valid bits and loads the register defaults.
// A stalled result freezes the whole pipeline; in_stall follows it.
// ============================================================================
module go_to_point_velocity_law
    import gtp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] pose_x,
    input  logic signed [15:0] pose_y,
    input  logic signed [15:0] heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] linear_cmd,
    output logic signed [14:0] angular_cmd,
    output logic               arrived,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [15:0]        wr_data
);

    localparam int LAT      = 3 + SQRT_STEPS + DIV_STEPS + 3;
    localparam int NEAR_DLY = SQRT_STEPS + DIV_STEPS + 3;
    localparam int HD_DLY   = SQRT_STEPS + DIV_STEPS - CORDIC_STEPS;
    localparam int NEAR_UV  = SQRT_STEPS + DIV_STEPS - 1;

    logic signed [15:0] target_x_reg;
    logic signed [15:0] target_y_reg;
    logic [14:0]        radius_reg;
    logic [14:0]        lin_gain_reg;
    logic [14:0]        ang_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg <= 16'sd0;
            target_y_reg <= 16'sd0;
            radius_reg   <= 15'd77;
            lin_gain_reg <= 15'd9830;
            ang_gain_reg <= 15'd9830;
        end
        else if (wr_en)
        begin
            case (reg_idx_t'(wr_index))
                REG_TARGET_X:       target_x_reg <= $signed(wr_data);
                REG_TARGET_Y:       target_y_reg <= $signed(wr_data);
                REG_ARRIVAL_RADIUS: radius_reg   <= wr_data[14:0];
                REG_LINEAR_GAIN:    lin_gain_reg <= wr_data[14:0];
                REG_ANGULAR_GAIN:   ang_gain_reg <= wr_data[14:0];
                default:            ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    logic vld_reg [LAT];

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_valid_reg <= vld_reg[LAT-1];
        end
    end

    // front: differences, squares, distance test
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic signed [15:0] hd1_reg;
    logic [32:0]        sqx_reg;
    logic [32:0]        sqy_reg;
    logic [29:0]        r2_reg;
    logic [16:0]        mx2_reg;
    logic [16:0]        my2_reg;
    logic               nx2_reg;
    logic               ny2_reg;
    logic signed [15:0] hd2_reg;
    logic [33:0]        c_reg;
    logic               near_reg;
    uv_in_t             uv3_reg;
    logic signed [15:0] hd3_reg;

    logic signed [33:0] sqx_full;
    logic signed [33:0] sqy_full;
    logic [29:0]        r2_full;
    logic [33:0]        c_next;

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign r2_full  = radius_reg * radius_reg;
    assign c_next   = 34'(sqx_reg) + 34'(sqy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= 17'(target_x_reg) - 17'(pose_x);
            dy_reg  <= 17'(target_y_reg) - 17'(pose_y);
            hd1_reg <= heading;

            sqx_reg <= sqx_full[32:0];
            sqy_reg <= sqy_full[32:0];
            r2_reg  <= r2_full;
            mx2_reg <= dx_reg[16] ? 17'(-dx_reg) : 17'(dx_reg);
            my2_reg <= dy_reg[16] ? 17'(-dy_reg) : 17'(dy_reg);
            nx2_reg <= dx_reg[16];
            ny2_reg <= dy_reg[16];
            hd2_reg <= hd1_reg;

            c_reg           <= c_next;
            near_reg        <= c_next <= 34'(r2_reg);
            uv3_reg.dist_sq <= c_next;
            uv3_reg.mag_x   <= mx2_reg;
            uv3_reg.mag_y   <= my2_reg;
            uv3_reg.neg_x   <= nx2_reg;
            uv3_reg.neg_y   <= ny2_reg;
            hd3_reg         <= hd2_reg;
        end
    end

    // align heading with the unit vector and the arrival flag with the gain products
    logic signed [15:0] hd_dly_reg   [HD_DLY];
    logic               near_dly_reg [NEAR_DLY];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hd_dly_reg[0] <= hd3_reg;
            for (int k = 1; k < HD_DLY; k++)
                hd_dly_reg[k] <= hd_dly_reg[k-1];
            near_dly_reg[0] <= near_reg;
            for (int k = 1; k < NEAR_DLY; k++)
                near_dly_reg[k] <= near_dly_reg[k-1];
        end
    end

    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [18:0] sin_q;
    logic signed [18:0] cos_q;

    gtp_unit_vec u_unit_vec (
        .clk (clk),
        .en  (adv),
        .op  (uv3_reg),
        .ux  (ux),
        .uy  (uy)
    );

    gtp_cordic u_cordic (
        .clk     (clk),
        .en      (adv),
        .heading (hd_dly_reg[HD_DLY-1]),
        .sin_q   (sin_q),
        .cos_q   (cos_q)
    );

    // back: rotate into robot frame, apply gains, round and saturate, zero on arrival
    logic signed [34:0] pcx_reg;
    logic signed [34:0] psy_reg;
    logic signed [34:0] pcy_reg;
    logic signed [34:0] psx_reg;
    logic signed [35:0] vx_reg;
    logic signed [35:0] vy_reg;
    logic signed [51:0] gx_reg;
    logic signed [51:0] gy_reg;
    logic signed [14:0] lin_reg;
    logic signed [14:0] ang_reg;
    logic               arr_reg;

    function automatic logic signed [14:0] round_sat(input logic signed [51:0] g);
        logic signed [52:0] rnd;
        logic signed [52:0] q;
        logic signed [14:0] r;
        rnd = 53'(g) + 53'sd1073741824;
        q   = rnd >>> 31;
        if (q > CMD_MAX)
            r = 15'(CMD_MAX);
        else if (q < CMD_MIN)
            r = 15'(CMD_MIN);
        else
            r = q[14:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pcx_reg <= cos_q * ux;
            psy_reg <= sin_q * uy;
            pcy_reg <= cos_q * uy;
            psx_reg <= sin_q * ux;

            vx_reg <= 36'(pcx_reg) + 36'(psy_reg);
            vy_reg <= 36'(pcy_reg) - 36'(psx_reg);

            gx_reg <= vx_reg * $signed({1'b0, lin_gain_reg});
            gy_reg <= vy_reg * $signed({1'b0, ang_gain_reg});

            arr_reg <= near_dly_reg[NEAR_DLY-1];
            lin_reg <= near_dly_reg[NEAR_DLY-1] ? 15'sd0 : round_sat(gx_reg);
            ang_reg <= near_dly_reg[NEAR_DLY-1] ? 15'sd0 : round_sat(gy_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign linear_cmd  = lin_reg;
    assign angular_cmd = ang_reg;
    assign arrived     = arr_reg;

    a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && arrived |-> linear_cmd == 15'sd0 && angular_cmd == 15'sd0)
        else $error("arrived result carries a nonzero command");

    a_zero_dist_near: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] && c_reg == 34'd0 |-> near_reg)
        else $error("zero distance not flagged as arrived");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3 + NEAR_UV] && !near_dly_reg[NEAR_UV]
            |-> ux <= 16'sd16384 && ux >= -16'sd16384 && uy <= 16'sd16384
                && uy >= -16'sd16384)
        else $error("unit vector component out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted request lost at pipeline entry");

endmodule

FILE: test/go_to_point_velocity_law_test.sv
// ============================================================================
// go_to_point_velocity_law_test
// Drives pose requests and register settings into the go-to-point law and
// checks every command against a bit-exact predictor kept in the testbench.
// ============================================================================
module go_to_point_velocity_law_test;
    import gtp_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [14:0] lin;
        logic signed [14:0] ang;
        logic               hit;
    } command_t;

    // ------------------------------------------------------------------------
    // command predictor and store of pending commands
    // ------------------------------------------------------------------------
    class command_board;
        longint   goal_x;
        longint   goal_y;
        longint   radius;
        longint   lin_gain;
        longint   ang_gain;
        command_t pending[$];
        int       errors;

        function void reset_regs();
            goal_x   = 0;
            goal_y   = 0;
            radius   = 77;
            lin_gain = 9830;
            ang_gain = 9830;
        endfunction

        function void write_reg(reg_idx_t idx, logic [15:0] data);
            case (idx)
                REG_TARGET_X:       goal_x   = longint'($signed(data));
                REG_TARGET_Y:       goal_y   = longint'($signed(data));
                REG_ARRIVAL_RADIUS: radius   = longint'(data[14:0]);
                REG_LINEAR_GAIN:    lin_gain = longint'(data[14:0]);
                REG_ANGULAR_GAIN:   ang_gain = longint'(data[14:0]);
                default: ;
            endcase
        endfunction

        function longint floor_div2(longint v, int s);
            return v >>> s;
        endfunction

        function longint root_of(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return longint'(r);
        endfunction

        function longint unit_of(longint d, longint s);
            longint q;
            q = ((d < 0 ? -d : d) <<< 29) / s;
            return d < 0 ? -q : q;
        endfunction

        function longint saturate(longint v, longint gain);
            longint r;
            r = floor_div2(v * gain + (64'sd1 <<< 30), 31);
            if (r > CMD_MAX)
                r = CMD_MAX;
            if (r < CMD_MIN)
                r = CMD_MIN;
            return r;
        endfunction

        function command_t predict(logic [15:0] px, logic [15:0] py, logic [15:0] hd);
            command_t c;
            longint dx, dy, dsq, s, ux, uy, z, x, y, t, sn, cs;
            bit flip;
            dx  = goal_x - longint'($signed(px));
            dy  = goal_y - longint'($signed(py));
            dsq = dx * dx + dy * dy;
            c   = '0;
            c.hit = 1'b1;
            if (dsq > radius * radius)
            begin
                s  = root_of(longint'(dsq) <<< 30);
                ux = unit_of(dx, s);
                uy = unit_of(dy, s);
                z  = longint'($signed(hd)) * 8;
                x  = CORDIC_K;
                y  = 0;
                flip = 0;
                if (z > HALF_PI_Q16)
                begin
                    z -= PI_Q16;
                    flip = 1;
                end
                else if (z < -HALF_PI_Q16)
                begin
                    z += PI_Q16;
                    flip = 1;
                end
                for (int i = 0; i < CORDIC_STEPS; i++)
                begin
                    if (z >= 0)
                    begin
                        t = x - (y >>> i);
                        y = y + (x >>> i);
                        z -= atan_q16(i);
                    end
                    else
                    begin
                        t = x + (y >>> i);
                        y = y - (x >>> i);
                        z += atan_q16(i);
                    end
                    x = t;
                end
                cs = flip ? -x : x;
                sn = flip ? -y : y;
                c.lin = 15'(saturate(cs * ux + sn * uy, lin_gain));
                c.ang = 15'(saturate(cs * uy - sn * ux, ang_gain));
                c.hit = 1'b0;
            end
            return c;
        endfunction

        function void note_pose(logic [15:0] px, logic [15:0] py, logic [15:0] hd);
            pending.push_back(predict(px, py, hd));
        endfunction

        function void check_command(command_t got);
            command_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected command lin=%0d ang=%0d arrived=%0b",
                             got.lin, got.ang, got.hit);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"command mismatch: expected lin=%0d ang=%0d arrived=%0b,",
                              " got lin=%0d ang=%0d arrived=%0b"},
                             want.lin, want.ang, want.hit, got.lin, got.ang, got.hit);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [15:0] heading;
    logic               out_valid;
    logic               out_stall;
    logic signed [14:0] linear_cmd;
    logic signed [14:0] angular_cmd;
    logic               arrived;
    logic               wr_en;
    logic [2:0]         wr_index;
    logic [15:0]        wr_data;

    command_board board;
    bit           hold_off_req;
    bit           pose_done;

    go_to_point_velocity_law u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pose_x     (pose_x),
        .pose_y     (pose_y),
        .heading    (heading),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .linear_cmd (linear_cmd),
        .angular_cmd(angular_cmd),
        .arrived    (arrived),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Hold the write for one edge; the caller drops wr_en after the last one.
    task automatic write_reg(reg_idx_t idx, logic [15:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // Offer one request, after a random gap unless steady, and hold it until accepted.
    task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [15:0] hd, bit steady);
        int g;
        g = steady ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        pose_x   <= px;
        pose_y   <= py;
        heading  <= hd;
        do
            @(posedge clk);
        while (in_stall);
        board.note_pose(px, py, hd);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // Four poses in ten around the target so that the arrival test is exercised.
    task automatic random_pose(output logic [15:0] px, output logic [15:0] py,
                               output logic [15:0] hd);
        int sel;
        int span;
        sel = $urandom_range(0, 9);
        hd  = 16'($urandom_range(0, 9) == 0 ? $urandom
                                            : $signed($urandom_range(0, 51472)) - 25736);
        if (sel < 4)
        begin
            span = 1 << $urandom_range(0, 10);
            px = 16'(board.goal_x + $signed($urandom_range(0, 2 * span)) - span);
            py = 16'(board.goal_y + $signed($urandom_range(0, 2 * span)) - span);
        end
        else
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
    endtask

    task automatic run_random(int count);
        logic [15:0] px, py, hd;
        for (int i = 0; i < count; i++)
        begin
            random_pose(px, py, hd);
            send_pose(px, py, hd, 1'b0);
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_req)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 : 1'b0;
    end

    initial
    begin
        hold_off_req = 0;
        @(posedge rst_n);
        repeat (400) @(posedge clk);
        hold_off_req = 1;
        repeat (200) @(posedge clk);
        hold_off_req = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_command({linear_cmd, angular_cmd, arrived});
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [15:0] rnd[5];
        board = new();
        board.reset_regs();
        board.errors = 0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        pose_x   = '0;
        pose_y   = '0;
        heading  = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, arrival edge, zero distance, wild headings
        send_pose(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pose(16'd77, 16'h0000, 16'h0000, 1'b1);
        send_pose(16'd78, 16'h0000, 16'h0000, 1'b1);
        send_pose(16'h8000, 16'h8000, 16'sd25736, 1'b1);
        send_pose(16'h7fff, 16'h7fff, -16'sd25736, 1'b1);
        send_pose(16'h8000, 16'h7fff, 16'h7fff, 1'b1);
        send_pose(16'h7fff, 16'h8000, 16'h8000, 1'b1);
        send_pose(16'h0100, 16'hff00, 16'hffff, 1'b1);
        send_pose(16'hff00, 16'h0100, 16'h3200, 1'b1);
        drain();
        write_reg(REG_TARGET_X, 16'h7fff);
        write_reg(REG_TARGET_Y, 16'h8000);
        write_reg(REG_ARRIVAL_RADIUS, 16'h0000);
        write_reg(REG_LINEAR_GAIN, 16'h7fff);
        write_reg(REG_ANGULAR_GAIN, 16'h7fff);
        wr_en <= 1'b0;
        send_pose(16'h7fff, 16'h8000, 16'h1234, 1'b1);
        send_pose(16'h7ffe, 16'h8000, 16'h0000, 1'b1);
        send_pose(16'h8000, 16'h7fff, 16'h6488, 1'b1);
        send_pose(16'h7fff, 16'h8001, 16'h9b78, 1'b1);
        send_pose(16'h0000, 16'h0000, 16'hc000, 1'b1);
        drain();
        write_reg(REG_ARRIVAL_RADIUS, 16'h7fff);
        write_reg(REG_LINEAR_GAIN, 16'h0000);
        write_reg(REG_ANGULAR_GAIN, 16'h0000);
        wr_en <= 1'b0;
        send_pose(16'h8000, 16'h7fff, 16'h0000, 1'b1);
        send_pose(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_pose(16'h8000, 16'h0000, 16'h2000, 1'b1);
        drain();

        // random phases with random settings, the last with maximum linear gain and angular gain one
        for (int ph = 0; ph < 8; ph++)
        begin
            foreach (rnd[k])
                rnd[k] = 16'($urandom);
            rnd[2] = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 2000));
            if (ph == 7)
            begin
                rnd[3] = 16'h7fff;
                rnd[4] = 16'h0001;
            end
            for (int k = 0; k < 5; k++)
                write_reg(reg_idx_t'(k), rnd[k]);
            wr_en <= 1'b0;
            // sender keeps offering during the receiver hold-off in phase 0
            run_random(200);
            // pause until every command is back
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
